// ===== hdl/dtec_pkg.sv =====
// Package for the DER TLV element checker: payload structs, parse phase and status codes,
// and the parser state record shared by the parser and the top level.
// No dependencies.
`default_nettype none

package dtec_pkg;

  localparam int unsigned MAX_LENGTH_BYTES = 4;
  localparam int unsigned LEN_FIELD_BYTES  = 4;

  localparam logic [1:0] MODE_ANY  = 2'd0;
  localparam logic [1:0] MODE_TAG  = 2'd1;
  localparam logic [1:0] MODE_INT  = 2'd2;
  localparam logic [1:0] MODE_BITS = 2'd3;

  localparam logic [0:0] REG_MODE         = 1'd0;
  localparam logic [0:0] REG_EXPECTED_TAG = 1'd1;

  localparam logic [7:0] TAG_INTEGER    = 8'h02;
  localparam logic [7:0] TAG_BIT_STRING = 8'h03;
  localparam logic [7:0] EXP_TAG_RESET  = 8'h30;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_REST   = 2'd2;

  typedef enum logic [3:0] {
    PH_TAG       = 4'b0001,
    PH_LEN_FIRST = 4'b0010,
    PH_LEN_MORE  = 4'b0100,
    PH_CONTENT   = 4'b1000
  } phase_t;

  typedef enum logic [3:0] {
    ST_HEADER      = 4'd0,
    ST_CONTENT     = 4'd1,
    ST_DONE        = 4'd2,
    ST_HIGH_TAG    = 4'd3,
    ST_BAD_FORM    = 4'd4,
    ST_NON_MINIMAL = 4'd5,
    ST_TRUNCATED   = 4'd6,
    ST_MISMATCH    = 4'd7,
    ST_BAD_INT     = 4'd8,
    ST_BAD_BITS    = 4'd9,
    ST_HALTED      = 4'd10
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_buffer;
    logic       last_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  element_tag;
    logic [31:0] content_length;
    logic [7:0]  value_byte;
    logic        value_valid;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] expected_tag;
  } cfg_regs_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  held_tag;
    logic [31:0] decoded_length;
    logic [2:0]  length_bytes_left;
    logic [31:0] content_left;
    logic [1:0]  content_position;
    logic        halted;
  } parse_state_t;

endpackage

`default_nettype wire

// ===== hdl/dtec_cfg.sv =====
// Configuration register file of the DER TLV element checker (mode, expected tag).
// Depends on dtec_pkg.
`default_nettype none

module dtec_cfg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  output dtec_pkg::cfg_regs_t     regs
);

  dtec_pkg::cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.mode         <= dtec_pkg::MODE_ANY;
      regs_r.expected_tag <= dtec_pkg::EXP_TAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtec_pkg::REG_MODE:         regs_r.mode         <= cfg_data[1:0];
        dtec_pkg::REG_EXPECTED_TAG: regs_r.expected_tag <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dtec_parse.sv =====
// Single-byte parse step of the DER TLV element checker: next parser state and result beat.
// Depends on dtec_pkg.
`default_nettype none

module dtec_parse (
  input  wire dtec_pkg::parse_state_t cur,
  input  wire dtec_pkg::in_beat_t     beat,
  input  wire dtec_pkg::cfg_regs_t    regs,
  output dtec_pkg::parse_state_t      nxt,
  output dtec_pkg::out_beat_t         res
);

  logic [7:0]      b;
  logic            last;
  logic [6:0]      count;
  logic            mismatch;
  logic            err;
  logic            valid;
  dtec_pkg::status_t st;

  assign b     = beat.data_byte;
  assign last  = beat.last_of_buffer;
  assign count = b[6:0];

  always_comb begin
    mismatch = ((regs.mode == dtec_pkg::MODE_TAG) && (b != regs.expected_tag)) ||
               ((regs.mode == dtec_pkg::MODE_INT) && (b != dtec_pkg::TAG_INTEGER)) ||
               ((regs.mode == dtec_pkg::MODE_BITS) && (b != dtec_pkg::TAG_BIT_STRING));
  end

  always_comb begin
    nxt   = cur;
    st    = dtec_pkg::ST_HEADER;
    valid = 1'b0;
    if (beat.first_of_buffer) begin
      nxt.halted            = 1'b0;
      nxt.phase             = dtec_pkg::PH_TAG;
      nxt.content_position  = dtec_pkg::POS_FIRST;
      nxt.length_bytes_left = 3'd0;
      nxt.content_left      = 32'd0;
    end
    if (nxt.halted) begin
      st = dtec_pkg::ST_HALTED;
    end else begin
      case (nxt.phase)
        dtec_pkg::PH_TAG: begin
          nxt.held_tag         = b;
          nxt.decoded_length   = 32'd0;
          nxt.content_position = dtec_pkg::POS_FIRST;
          if (last) begin
            st = dtec_pkg::ST_TRUNCATED;
          end else if (b[4:0] == 5'h1f) begin
            st = dtec_pkg::ST_HIGH_TAG;
          end else if (mismatch) begin
            st = dtec_pkg::ST_MISMATCH;
          end else begin
            nxt.phase = dtec_pkg::PH_LEN_FIRST;
          end
        end
        dtec_pkg::PH_LEN_FIRST: begin
          if (!b[7]) begin
            nxt.decoded_length = {24'd0, b};
            if (b == 8'd0) begin
              nxt.phase = dtec_pkg::PH_TAG;
              if (regs.mode == dtec_pkg::MODE_INT) begin
                st = dtec_pkg::ST_BAD_INT;
              end else if (regs.mode == dtec_pkg::MODE_BITS) begin
                st = dtec_pkg::ST_BAD_BITS;
              end else begin
                st = dtec_pkg::ST_DONE;
              end
            end else begin
              nxt.content_left     = {24'd0, b};
              nxt.content_position = dtec_pkg::POS_FIRST;
              nxt.phase            = dtec_pkg::PH_CONTENT;
              if (last) begin
                st = dtec_pkg::ST_TRUNCATED;
              end
            end
          end else if ((count == 7'd0) ||
                       ({25'd0, count} > dtec_pkg::MAX_LENGTH_BYTES) ||
                       ({25'd0, count} > dtec_pkg::LEN_FIELD_BYTES)) begin
            st = dtec_pkg::ST_BAD_FORM;
          end else begin
            nxt.decoded_length    = 32'd0;
            nxt.length_bytes_left = count[2:0];
            nxt.phase             = dtec_pkg::PH_LEN_MORE;
            if (last) begin
              st = dtec_pkg::ST_TRUNCATED;
            end
          end
        end
        dtec_pkg::PH_LEN_MORE: begin
          if ((nxt.decoded_length == 32'd0) && (b == 8'd0)) begin
            st = dtec_pkg::ST_NON_MINIMAL;
          end else begin
            nxt.decoded_length    = {nxt.decoded_length[23:0], b};
            nxt.length_bytes_left = nxt.length_bytes_left - 3'd1;
            if ((nxt.length_bytes_left == 3'd0) && (nxt.decoded_length < 32'h80)) begin
              st = dtec_pkg::ST_NON_MINIMAL;
            end else begin
              if (nxt.length_bytes_left == 3'd0) begin
                nxt.content_left     = nxt.decoded_length;
                nxt.content_position = dtec_pkg::POS_FIRST;
                nxt.phase            = dtec_pkg::PH_CONTENT;
              end
              if (last) begin
                st = dtec_pkg::ST_TRUNCATED;
              end
            end
          end
        end
        dtec_pkg::PH_CONTENT: begin
          valid = 1'b1;
          if ((regs.mode == dtec_pkg::MODE_INT) &&
              (nxt.content_position == dtec_pkg::POS_FIRST)) begin
            if (b[7]) begin
              st = dtec_pkg::ST_BAD_INT;
            end else if ((b == 8'd0) && (nxt.content_left > 32'd1)) begin
              valid                = 1'b0;
              nxt.content_position = dtec_pkg::POS_SECOND;
            end else begin
              nxt.content_position = dtec_pkg::POS_REST;
            end
          end else if ((regs.mode == dtec_pkg::MODE_INT) &&
                       (nxt.content_position == dtec_pkg::POS_SECOND)) begin
            if (!b[7]) begin
              st = dtec_pkg::ST_BAD_INT;
            end else begin
              nxt.content_position = dtec_pkg::POS_REST;
            end
          end else if ((regs.mode == dtec_pkg::MODE_BITS) &&
                       (nxt.content_position == dtec_pkg::POS_FIRST)) begin
            if (b != 8'd0) begin
              st = dtec_pkg::ST_BAD_BITS;
            end else begin
              valid                = 1'b0;
              nxt.content_position = dtec_pkg::POS_REST;
            end
          end else begin
            nxt.content_position = dtec_pkg::POS_REST;
          end
          if (st == dtec_pkg::ST_HEADER) begin
            nxt.content_left = nxt.content_left - 32'd1;
            if (nxt.content_left == 32'd0) begin
              nxt.phase            = dtec_pkg::PH_TAG;
              nxt.content_position = dtec_pkg::POS_FIRST;
              st                   = dtec_pkg::ST_DONE;
            end else if (last) begin
              st = dtec_pkg::ST_TRUNCATED;
            end else begin
              st = dtec_pkg::ST_CONTENT;
            end
          end
        end
        default: begin
          st = dtec_pkg::ST_HALTED;
        end
      endcase
    end
    err = (st >= dtec_pkg::ST_HIGH_TAG);
    if (err) begin
      nxt.halted = 1'b1;
    end
  end

  always_comb begin
    res.status         = st;
    res.element_tag    = nxt.held_tag;
    res.content_length = nxt.decoded_length;
    res.value_valid    = !err && valid;
    res.value_byte     = (!err && valid) ? b : 8'd0;
  end

endmodule

`default_nettype wire

// ===== hdl/der_tlv_element_checker_unit.sv =====
// Top level of the DER TLV element checker: input register, parser state, result register.
// Depends on dtec_pkg, dtec_cfg and dtec_parse.
//
// Usage: a DER buffer enters one byte per beat on the in_ channel (valid/stall), with
// first_of_buffer on its first byte and last_of_buffer on its final byte. Every input
// beat produces exactly one result beat on the out_ channel: a status code, the tag and
// decoded length of the current element, and the value byte after stripping.
// Throughput is one byte per cycle while the receiver does not stall. An accepted byte
// is held in the input register while the parse step, whose single-byte logic (tag compare,
// length shift, 32-bit content countdown) sits between the input register and the result
// register, computes the result that the result register then loads.
// When the receiver stalls, the result beat holds and the input register keeps its byte;
// in_stall rises only when the input register is full and cannot move on.
// The cfg_ channel writes mode (index 0) and expected_tag (index 1); it is always ready
// and should be written only while no bytes are in flight.
// Synchronous reset clears both registers' valid flags, returns the parser to expecting
// a tag byte, and sets mode to 0 and expected_tag to 0x30.
`default_nettype none

module der_tlv_element_checker_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire dtec_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dtec_pkg::out_beat_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [7:0]          cfg_data
);

  dtec_pkg::cfg_regs_t    regs;
  dtec_pkg::parse_state_t state_r;
  dtec_pkg::parse_state_t state_nxt;
  dtec_pkg::in_beat_t     in_beat_r;
  dtec_pkg::out_beat_t    out_beat_r;
  dtec_pkg::out_beat_t    out_beat_nxt;
  logic                   in_vld_r;
  logic                   out_vld_r;
  logic                   advance;

  dtec_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  dtec_parse u_parse (
    .cur  (state_r),
    .beat (in_beat_r),
    .regs (regs),
    .nxt  (state_nxt),
    .res  (out_beat_nxt)
  );

  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r.phase             <= dtec_pkg::PH_TAG;
      state_r.held_tag          <= 8'd0;
      state_r.decoded_length    <= 32'd0;
      state_r.length_bytes_left <= 3'd0;
      state_r.content_left      <= 32'd0;
      state_r.content_position  <= dtec_pkg::POS_FIRST;
      state_r.halted            <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_beat_r <= in_data;
    end
    if (advance) begin
      out_beat_r <= out_beat_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dtec_checker.sv =====
// Port-level checker for the DER TLV element checker, bound to the top level.
// Depends on dtec_pkg and der_tlv_element_checker_unit.
`default_nettype none

module dtec_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire dtec_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result beat changed.");

  a_value_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.value_valid |->
      (out_data.status == dtec_pkg::ST_CONTENT) || (out_data.status == dtec_pkg::ST_DONE))
    else $error("Value byte flagged on a beat that is not a content beat.");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status >= dtec_pkg::ST_HIGH_TAG) |->
      (out_data.value_byte == 8'd0) && !out_data.value_valid)
    else $error("Error beat carries value data.");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= dtec_pkg::ST_HALTED)
    else $error("Status code out of range.");

endmodule

bind der_tlv_element_checker_unit dtec_checker u_dtec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
